// ----- sv/periodic_event_timer_table_top_macros.svh -----
// Assertion macros for the periodic event timer table
`ifndef PERIODIC_EVENT_TIMER_TABLE_TOP_MACROS_SVH
`define PERIODIC_EVENT_TIMER_TABLE_TOP_MACROS_SVH
// Implication checked at every clock edge outside reset
`define PETT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");
// Next-cycle implication
`define PETT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// ----- sv/pett_pkg.sv -----
// Package: types and constants for the periodic event timer table
`timescale 1ns / 1ps
`default_nettype none
package pett_pkg;
    localparam int SLOTS = 16;
    localparam int IDX_W = $clog2(SLOTS);
    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam int QDEPTH = 2;

    typedef enum logic [2:0] {
        REQ_TICK = 3'd0, REQ_ADD = 3'd1, REQ_RM_TYPE = 3'd2,
        REQ_RM_ID = 3'd3, REQ_RM_ID_IVL = 3'd4, REQ_CLEAR = 3'd5,
        REQ_NOP6 = 3'd6, REQ_NOP7 = 3'd7
    } t_req;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_BAD_COUNT = 2'd2;
    localparam logic [1:0] ST_NONE = 2'd3;

    typedef struct packed {
        logic [2:0]         req_type;
        logic [15:0]        event_id;
        logic [7:0]         event_type;
        logic [31:0]        interval_ms;
        logic signed [15:0] repeat_count;
        logic [31:0]        elapsed_ms;
    } t_in;

    typedef struct packed {
        logic        fired;
        logic [15:0] fired_event_id;
        logic [31:0] next_wait_ms;
        logic [1:0]  status;
        logic        last;
    } t_out;

    // Classified command handed from front to back
    typedef struct packed {
        t_req               op;
        logic               bad_count;
        logic [15:0]        event_id;
        logic [7:0]         event_type;
        logic [31:0]        interval_ms;
        logic signed [15:0] repeat_count;
        logic [31:0]        elapsed_ms;
    } t_cmd;

    typedef enum logic [1:0] {
        BK_IDLE, BK_WALK, BK_DONE
    } t_bk_state;
endpackage
`default_nettype wire

// ----- sv/pett_front.sv -----
// Front end: accepts requests, classifies them and queues commands
`timescale 1ns / 1ps
`default_nettype none
module pett_front (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_stall,
    input  wire pett_pkg::t_in  i_data,
    output logic                o_cmd_valid,
    input  wire logic           i_cmd_take,
    output pett_pkg::t_cmd      o_cmd
);
    pett_pkg::t_cmd r_q [pett_pkg::QDEPTH];
    logic           r_wp, r_rp;
    logic [1:0]     r_cnt;
    logic [1:0]     n_cnt;
    pett_pkg::t_cmd w_cmd;
    logic           w_push, w_pop;

    always_comb begin
        w_cmd.op = pett_pkg::t_req'(i_data.req_type);
        w_cmd.bad_count = !(i_data.repeat_count == -16'sd1 || i_data.repeat_count > 16'sd0);
        w_cmd.event_id = i_data.event_id;
        w_cmd.event_type = i_data.event_type;
        w_cmd.interval_ms = i_data.interval_ms;
        w_cmd.repeat_count = i_data.repeat_count;
        w_cmd.elapsed_ms = i_data.elapsed_ms;
    end

    assign o_stall = (r_cnt == 2'd2);
    assign w_push = i_valid && !o_stall;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign w_pop = o_cmd_valid && i_cmd_take;
    assign o_cmd = r_q[r_rp];

    always_comb begin
        n_cnt = r_cnt;
        if (w_push && !w_pop) n_cnt = r_cnt + 2'd1;
        else if (!w_push && w_pop) n_cnt = r_cnt - 2'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (w_push) r_wp <= ~r_wp;
            if (w_pop) r_rp <= ~r_rp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) r_q[r_wp] <= w_cmd;
    end
endmodule
`default_nettype wire

// ----- sv/pett_back.sv -----
// Back end: walks the slot table and produces results
`timescale 1ns / 1ps
`default_nettype none
module pett_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_cmd_valid,
    output logic                 o_cmd_take,
    input  wire pett_pkg::t_cmd  i_cmd,
    output logic                 o_valid,
    input  wire logic            i_stall,
    output pett_pkg::t_out       o_data
);
    localparam int IW = pett_pkg::IDX_W;
    localparam int CW = pett_pkg::CNT_W;

    logic [15:0]        r_id   [pett_pkg::SLOTS];
    logic [7:0]         r_ty   [pett_pkg::SLOTS];
    logic [31:0]        r_ivl  [pett_pkg::SLOTS];
    logic [31:0]        r_rem  [pett_pkg::SLOTS];
    logic signed [15:0] r_rep  [pett_pkg::SLOTS];

    pett_pkg::t_bk_state r_state, n_state;
    pett_pkg::t_cmd      r_cmd;
    logic [CW-1:0]       r_count;
    logic [CW-1:0]       r_rd, r_wr;
    logic [31:0]         r_wait;
    logic                r_found;
    logic                r_ovalid;
    logic                n_ovalid;
    pett_pkg::t_out      r_out;

    logic [IW-1:0] w_ri, w_wi;
    logic          w_out_free, w_walk_end;
    logic          w_drop, w_fire, w_keep;
    logic [31:0]   w_nrem;
    logic signed [15:0] w_nrep;
    logic          w_emit_fire;
    logic          w_step;

    assign w_out_free = !r_ovalid || !i_stall;
    assign w_ri = r_rd[IW-1:0];
    assign w_wi = r_wr[IW-1:0];
    assign w_walk_end = (r_rd >= r_count);
    assign o_valid = r_ovalid;
    assign o_data = r_out;

    // Per-slot decision during a walk
    always_comb begin
        w_drop = 1'b0;
        w_fire = 1'b0;
        w_nrem = r_rem[w_ri];
        w_nrep = r_rep[w_ri];
        case (r_cmd.op)
            pett_pkg::REQ_TICK: begin
                w_drop = (r_rep[w_ri] == 16'sd0);
                w_fire = !w_drop && (r_rem[w_ri] <= r_cmd.elapsed_ms);
                if (w_fire) begin
                    w_nrem = r_ivl[w_ri];
                    if (r_rep[w_ri] > 16'sd0) w_nrep = r_rep[w_ri] - 16'sd1;
                end else begin
                    w_nrem = r_rem[w_ri] - r_cmd.elapsed_ms;
                end
            end
            pett_pkg::REQ_RM_TYPE: w_drop = (r_ty[w_ri] == r_cmd.event_type);
            pett_pkg::REQ_RM_ID: w_drop = !r_found && (r_id[w_ri] == r_cmd.event_id);
            pett_pkg::REQ_RM_ID_IVL: w_drop = !r_found && (r_id[w_ri] == r_cmd.event_id)
                                              && (r_ivl[w_ri] == r_cmd.interval_ms);
            default: w_drop = 1'b0;
        endcase
        w_keep = !w_drop;
    end

    assign w_emit_fire = w_fire;

    // Walk advances one slot; a firing waits for a free output register
    assign w_step = (r_state == pett_pkg::BK_WALK) && !w_walk_end
                    && (!w_fire || w_out_free);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            pett_pkg::BK_IDLE: if (i_cmd_valid) n_state = pett_pkg::BK_WALK;
            pett_pkg::BK_WALK: if (w_walk_end || (w_emit_fire == 1'b0) || w_out_free) begin
                if (w_walk_end) n_state = pett_pkg::BK_DONE;
            end
            pett_pkg::BK_DONE: if (w_out_free) n_state = pett_pkg::BK_IDLE;
            default: n_state = pett_pkg::BK_IDLE;
        endcase
    end

    // Outputs of the state machine
    always_comb begin
        o_cmd_take = (r_state == pett_pkg::BK_IDLE) && i_cmd_valid;
        n_ovalid = r_ovalid && i_stall;
        if (w_step && w_fire) n_ovalid = 1'b1;
        if ((r_state == pett_pkg::BK_DONE) && w_out_free) n_ovalid = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pett_pkg::BK_IDLE;
            r_count <= '0;
            r_ovalid <= 1'b0;
            r_rd <= '0;
            r_wr <= '0;
            r_found <= 1'b0;
            r_wait <= '0;
        end else begin
            r_state <= n_state;
            r_ovalid <= n_ovalid;
            case (r_state)
                pett_pkg::BK_IDLE: begin
                    r_wr <= '0;
                    r_found <= 1'b0;
                    r_wait <= '0;
                    if (i_cmd_valid) r_cmd <= i_cmd;
                    // Adds, clears and unknown codes skip the walk
                    if (i_cmd_valid && !(i_cmd.op inside {pett_pkg::REQ_TICK,
                            pett_pkg::REQ_RM_TYPE, pett_pkg::REQ_RM_ID,
                            pett_pkg::REQ_RM_ID_IVL})) begin
                        r_rd <= r_count;
                    end else begin
                        r_rd <= '0;
                    end
                end
                pett_pkg::BK_WALK: begin
                    if (w_step) begin
                        r_rd <= r_rd + CW'(1);
                        if (w_keep) begin
                            r_id[w_wi] <= r_id[w_ri];
                            r_ty[w_wi] <= r_ty[w_ri];
                            r_ivl[w_wi] <= r_ivl[w_ri];
                            r_rem[w_wi] <= w_nrem;
                            r_rep[w_wi] <= w_nrep;
                            r_wr <= r_wr + CW'(1);
                            if (w_nrem != 32'd0 && (r_wait == 32'd0 || w_nrem < r_wait))
                                r_wait <= w_nrem;
                        end else begin
                            r_found <= 1'b1;
                        end
                        if (w_fire) begin
                            r_out <= '{1'b1, r_id[w_ri], 32'd0, pett_pkg::ST_OK, 1'b0};
                        end
                    end
                end
                pett_pkg::BK_DONE: begin
                    if (w_out_free) begin
                        case (r_cmd.op)
                            pett_pkg::REQ_TICK: begin
                                r_out <= '{1'b0, 16'd0, r_wait, pett_pkg::ST_OK, 1'b1};
                                r_count <= r_wr;
                            end
                            pett_pkg::REQ_RM_TYPE, pett_pkg::REQ_RM_ID,
                            pett_pkg::REQ_RM_ID_IVL: begin
                                r_count <= r_wr;
                                r_out <= '{1'b0, 16'd0, 32'd0,
                                           r_found ? pett_pkg::ST_OK : pett_pkg::ST_NONE,
                                           1'b1};
                            end
                            pett_pkg::REQ_ADD: begin
                                if (r_cmd.bad_count) begin
                                    r_out <= '{1'b0, 16'd0, 32'd0,
                                               pett_pkg::ST_BAD_COUNT, 1'b1};
                                end else if (r_count >= CW'(pett_pkg::SLOTS)) begin
                                    r_out <= '{1'b0, 16'd0, 32'd0, pett_pkg::ST_FULL, 1'b1};
                                end else begin
                                    r_out <= '{1'b0, 16'd0, 32'd0, pett_pkg::ST_OK, 1'b1};
                                    r_id[r_count[IW-1:0]] <= r_cmd.event_id;
                                    r_ty[r_count[IW-1:0]] <= r_cmd.event_type;
                                    r_ivl[r_count[IW-1:0]] <= r_cmd.interval_ms;
                                    r_rem[r_count[IW-1:0]] <= r_cmd.interval_ms;
                                    r_rep[r_count[IW-1:0]] <= r_cmd.repeat_count;
                                    r_count <= r_count + CW'(1);
                                end
                            end
                            pett_pkg::REQ_CLEAR: begin
                                r_out <= '{1'b0, 16'd0, 32'd0, pett_pkg::ST_OK, 1'b1};
                                r_count <= '0;
                            end
                            default: r_out <= '{1'b0, 16'd0, 32'd0, pett_pkg::ST_OK, 1'b1};
                        endcase
                    end
                end
                default: r_rd <= '0;
            endcase
        end
    end
endmodule
`default_nettype wire

// ----- sv/periodic_event_timer_table_top.sv -----
// Top level of the periodic event timer table
// Usage:
//  - Request channel i_valid / o_stall carries one t_in per request; the
//    result channel o_valid / i_stall carries t_out result items.
//  - A tick walks all held events in insertion order: one result per
//    firing event (fired=1, last=0), then a summary with next_wait_ms and
//    last=1. Other requests give one result with a status and last=1.
//  - Sequence: a request enters a two-entry queue, the back end takes it
//    when idle, walks the held events (up to 16), closes the walk and
//    then registers the summary. A new request starts once the previous
//    summary is registered.
//  - The walk rate is set by the single slot pass: one slot read and
//    compacted per cycle, unless a firing waits for the output register.
//  - A stalled receiver holds the output register; the walk pauses on the
//    next firing or summary, while the queue keeps taking requests until
//    it is full, then o_stall rises.
//  - Synchronous active-low reset empties the table and the queue; slot
//    contents are not cleared and are only read below the event count.
`timescale 1ns / 1ps
`default_nettype none
module periodic_event_timer_table_top (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_stall,
    input  wire pett_pkg::t_in  i_data,
    output logic                o_valid,
    input  wire logic           i_stall,
    output pett_pkg::t_out      o_data
);
    logic           w_cmd_valid, w_cmd_take;
    pett_pkg::t_cmd w_cmd;

    // front: classify and queue requests
    pett_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall), .i_data(i_data),
        .o_cmd_valid(w_cmd_valid), .i_cmd_take(w_cmd_take), .o_cmd(w_cmd)
    );

    // back: table walk and results
    pett_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cmd_valid(w_cmd_valid), .o_cmd_take(w_cmd_take), .i_cmd(w_cmd),
        .o_valid(o_valid), .i_stall(i_stall), .o_data(o_data)
    );
endmodule
`default_nettype wire

// ----- sv/pett_checker.sv -----
// Port-level checker for the periodic event timer table
`timescale 1ns / 1ps
`default_nettype none
`include "periodic_event_timer_table_top_macros.svh"
module pett_checker (
    input wire logic           i_clk,
    input wire logic           i_rst_n,
    input wire logic           o_valid,
    input wire logic           i_stall,
    input wire pett_pkg::t_out o_data
);
    logic w_fire_clean;

    // A firing carries ok status and no wait time
    assign w_fire_clean = (o_data.status == pett_pkg::ST_OK) && (o_data.next_wait_ms == 32'd0);

    `PETT_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_data))
    `PETT_ASSERT_IMP(a_fire_not_last, i_clk, i_rst_n, o_valid && o_data.fired, !o_data.last)
    `PETT_ASSERT_IMP(a_fire_ok, i_clk, i_rst_n, o_valid && o_data.fired, w_fire_clean)
    `PETT_ASSERT_IMP(a_nonlast_fires, i_clk, i_rst_n, o_valid && !o_data.last, o_data.fired)
endmodule
bind periodic_event_timer_table_top pett_checker u_pett_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .o_valid(o_valid), .i_stall(i_stall), .o_data(o_data)
);
`default_nettype wire
